// ===== hw/rtl/pst_pkg.sv =====
// Shared types and constants for the pump schedule timer.
// No dependencies; every other file of the block imports this package.
package pst_pkg;

   // Field and register widths
   localparam int unsigned CmdWidth      = 3;
   localparam int unsigned TimeWidth     = 32;
   localparam int unsigned MinutesWidth  = 16;
   localparam int unsigned IntervalWidth = 25;
   localparam int unsigned CsrIndexWidth = 1;
   localparam int unsigned CsrDataWidth  = 25;

   // Wall-clock seconds below this mean the clock has not been synced yet
   localparam logic [TimeWidth-1:0]    EpochSyncMin  = 32'd1000000000;
   localparam logic [MinutesWidth-1:0] MsPerMinute   = 16'd60000;
   localparam logic [MinutesWidth-1:0] DurationReset = 16'd30;

   // Command codes
   typedef enum logic [CmdWidth-1:0] {
      CmdTick     = 3'd0,
      CmdCheck    = 3'd1,
      CmdOn       = 3'd2,
      CmdOff      = 3'd3,
      CmdToggle   = 3'd4,
      CmdSkip     = 3'd5,
      CmdTimedOn  = 3'd6
   } cmd_type;

   // Configuration register indexes
   typedef enum logic [CsrIndexWidth-1:0] {
      CsrInterval = 1'd0,
      CsrDuration = 1'd1
   } csr_index_type;

   typedef struct packed {
      logic [IntervalWidth-1:0] interval_seconds;
      logic [MinutesWidth-1:0]  duration_minutes;
   } cfg_type;

   typedef struct packed {
      logic                 pump_on;
      logic                 skip;
      logic                 deadline_valid;
      logic [TimeWidth-1:0] off_deadline;
      logic                 next_valid;
      logic [TimeWidth-1:0] next_due_epoch;
   } state_type;

   typedef struct packed {
      logic [CmdWidth-1:0]     cmd;
      logic [TimeWidth-1:0]    now_ms;
      logic [TimeWidth-1:0]    now_epoch;
      logic [MinutesWidth-1:0] timed_minutes;
   } item_type;

   typedef struct packed {
      logic                 pump_running;
      logic                 pump_updated;
      logic                 deadline_armed;
      logic [TimeWidth-1:0] off_deadline_ms;
      logic [TimeWidth-1:0] next_watering_epoch;
      logic                 skip_pending;
   } result_type;

endpackage

// ===== hw/rtl/pst_update.sv =====
// Next-state and result logic for one item of the pump schedule timer.
// Depends on pst_pkg; purely combinational, used by pst_state.
module pst_update (
   input  pst_pkg::cfg_type    cfg,
   input  pst_pkg::state_type  cur,
   input  pst_pkg::item_type   item,
   output pst_pkg::state_type  nxt,
   output pst_pkg::result_type result
);
   import pst_pkg::*;

   logic [MinutesWidth-1:0] minutes_sel;
   logic [TimeWidth-1:0]    span_ms;
   logic [TimeWidth-1:0]    deadline_sum;
   logic [TimeWidth-1:0]    interval_ext;
   logic                    sched_enabled;
   logic                    updated;

   // One shared multiplier: timed-on minutes or the scheduled duration
   assign minutes_sel  = (item.cmd == CmdTimedOn) ? item.timed_minutes : cfg.duration_minutes;
   assign span_ms      = TimeWidth'(minutes_sel) * TimeWidth'(MsPerMinute);
   assign deadline_sum = item.now_ms + span_ms;
   assign interval_ext = TimeWidth'(cfg.interval_seconds);

   assign sched_enabled = (cfg.interval_seconds != '0) && (cfg.duration_minutes != '0)
                          && (item.now_epoch >= EpochSyncMin);

   // Apply the command to the current state
   always_comb begin
      nxt     = cur;
      updated = 1'b0;
      unique case (item.cmd)
         CmdTick: begin
            if (cur.deadline_valid && (item.now_ms >= cur.off_deadline)) begin
               nxt.pump_on        = 1'b0;
               nxt.deadline_valid = 1'b0;
               nxt.off_deadline   = '0;
               updated            = 1'b1;
            end
         end
         CmdCheck: begin
            if (sched_enabled) begin
               if (!cur.next_valid) begin
                  nxt.next_due_epoch = item.now_epoch + interval_ext;
                  nxt.next_valid     = 1'b1;
               end else if (item.now_epoch >= cur.next_due_epoch) begin
                  nxt.next_due_epoch = cur.next_due_epoch + interval_ext;
                  if (cur.skip) begin
                     nxt.skip = 1'b0;
                  end else if (!cur.pump_on) begin
                     nxt.pump_on        = 1'b1;
                     nxt.deadline_valid = 1'b1;
                     nxt.off_deadline   = deadline_sum;
                     updated            = 1'b1;
                  end
               end
            end
         end
         CmdOn: begin
            nxt.pump_on = 1'b1;
            updated     = 1'b1;
         end
         CmdOff: begin
            nxt.pump_on        = 1'b0;
            nxt.deadline_valid = 1'b0;
            nxt.off_deadline   = '0;
            updated            = 1'b1;
         end
         CmdToggle: begin
            nxt.pump_on = !cur.pump_on;
            if (cur.pump_on) begin
               nxt.deadline_valid = 1'b0;
               nxt.off_deadline   = '0;
            end
            updated = 1'b1;
         end
         CmdSkip: begin
            nxt.skip = 1'b1;
         end
         CmdTimedOn: begin
            if (item.timed_minutes != '0) begin
               nxt.pump_on        = 1'b1;
               nxt.deadline_valid = 1'b1;
               nxt.off_deadline   = deadline_sum;
               updated            = 1'b1;
            end
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

   // Report the state after the item
   always_comb begin
      result.pump_running        = nxt.pump_on;
      result.pump_updated        = updated;
      result.deadline_armed      = nxt.deadline_valid;
      result.off_deadline_ms     = nxt.deadline_valid ? nxt.off_deadline : '0;
      result.next_watering_epoch = nxt.next_valid ? nxt.next_due_epoch : '0;
      result.skip_pending        = nxt.skip;
   end

endmodule

// ===== hw/rtl/pst_state.sv =====
// Configuration and controller state registers of the pump schedule timer.
// Depends on pst_pkg and pst_update.
module pst_state (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [pst_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [pst_pkg::CsrDataWidth-1:0]  csr_write_data,
   input  logic                              advance,
   input  pst_pkg::item_type                 item,
   output pst_pkg::result_type               result
);
   import pst_pkg::*;

   cfg_type   cfg_ff;
   cfg_type   cfg_in;
   state_type state_ff;
   state_type state_in;
   state_type state_upd;

   pst_update u_update (
      .cfg    (cfg_ff),
      .cur    (state_ff),
      .item   (item),
      .nxt    (state_upd),
      .result (result)
   );

   // Register writes; an interval write drops the next watering time
   always_comb begin
      cfg_in   = cfg_ff;
      state_in = advance ? state_upd : state_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CsrInterval: begin
               cfg_in.interval_seconds = csr_write_data[IntervalWidth-1:0];
               state_in.next_valid     = 1'b0;
               state_in.next_due_epoch = '0;
            end
            CsrDuration: begin
               cfg_in.duration_minutes = csr_write_data[MinutesWidth-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   // Hold configuration and state
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.interval_seconds <= '0;
         cfg_ff.duration_minutes <= DurationReset;
         state_ff                <= '0;
      end else begin
         cfg_ff   <= cfg_in;
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/pump_schedule_timer_core.sv =====
// Top level of the pump schedule timer: input register, state update, result register.
// Depends on pst_pkg and pst_state.
//
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_stall   cmd, now_ms, now_epoch, timed_minutes
//   rsp_      out        rsp_valid/rsp_stall   pump_running .. skip_pending
//   csr_      in         csr_write_enable      csr_index, csr_write_data
//
// One item per cycle while rsp_ is not stalled; an accepted item passes the input register
// and then the result register, which loads it as it moves on and then shows it valid.
// The state update sits between the input register and the result register.
// Reset is synchronous; no clearing pass.
// A stalled result holds the input register, which in turn stalls req_.
module pump_schedule_timer_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [pst_pkg::CmdWidth-1:0]      req_cmd,
   input  logic [pst_pkg::TimeWidth-1:0]     req_now_ms,
   input  logic [pst_pkg::TimeWidth-1:0]     req_now_epoch,
   input  logic [pst_pkg::MinutesWidth-1:0]  req_timed_minutes,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_pump_running,
   output logic                              rsp_pump_updated,
   output logic                              rsp_deadline_armed,
   output logic [pst_pkg::TimeWidth-1:0]     rsp_off_deadline_ms,
   output logic [pst_pkg::TimeWidth-1:0]     rsp_next_watering_epoch,
   output logic                              rsp_skip_pending,
   input  logic                              csr_write_enable,
   input  logic [pst_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [pst_pkg::CsrDataWidth-1:0]  csr_write_data
);
   import pst_pkg::*;

   logic       in_valid_ff;
   logic       in_valid_in;
   item_type   in_item_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   result_type rsp_ff;
   result_type result;
   logic       advance;
   logic       req_take;

   // Move an item on when the result register is free or being drained
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   pst_state u_state (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .advance          (advance),
      .item             (in_item_ff),
      .result           (result)
   );

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_take) begin
         in_item_ff.cmd           <= req_cmd;
         in_item_ff.now_ms        <= req_now_ms;
         in_item_ff.now_epoch     <= req_now_epoch;
         in_item_ff.timed_minutes <= req_timed_minutes;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_pump_running        = rsp_ff.pump_running;
   assign rsp_pump_updated        = rsp_ff.pump_updated;
   assign rsp_deadline_armed      = rsp_ff.deadline_armed;
   assign rsp_off_deadline_ms     = rsp_ff.off_deadline_ms;
   assign rsp_next_watering_epoch = rsp_ff.next_watering_epoch;
   assign rsp_skip_pending        = rsp_ff.skip_pending;

   // A reported deadline is zero unless one is armed
   a_deadline_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.deadline_armed || (rsp_ff.off_deadline_ms == '0)))
      else $error("off deadline reported without an armed deadline");

   // Switching the pump off always drops the deadline
   a_off_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.pump_updated && !rsp_ff.pump_running)
      |-> !rsp_ff.deadline_armed)
      else $error("deadline still armed after switch-off");

   // An item that moves on shows up as a result in the next cycle
   a_advance_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced item lost before the result register");

   // Stall back to the requester only while the input and result registers are both occupied
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid_ff))
      else $error("request stalled with room in the pipeline");

endmodule
